FILE: hdl/ray_partial_disk_intersect_assert.svh
// Assertion macros used by the ray-disk back pipeline module.
`ifndef RAY_PARTIAL_DISK_INTERSECT_ASSERT_SVH
`define RAY_PARTIAL_DISK_INTERSECT_ASSERT_SVH

// Assert that a condition implies another one in the same cycle.
`define RPD_ASSERT_IMP(label, clk_sig, rst_n_sig, lhs, rhs) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (lhs) |-> (rhs)) \
		else $error("assertion failed");

// Assert that a condition implies another one in the next cycle.
`define RPD_ASSERT_NXT(label, clk_sig, rst_n_sig, lhs, rhs) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (lhs) |=> (rhs)) \
		else $error("assertion failed");

`endif

FILE: hdl/rpdi_pkg.sv
package rpdi_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int CORDIC_STEPS = 30;
	localparam int UV_BITS = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SWEEP  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NEAR   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FAR    = 3'd4;

	localparam logic [34:0] PI_Q30      = 35'd3373259426;
	localparam logic [34:0] HALF_PI_Q30 = 35'd1686629713;
	localparam logic [34:0] TWO_PI_Q30  = 35'd6746518852;

	typedef struct packed {
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic signed [31:0] origin_z;
		logic signed [31:0] dir_x;
		logic signed [31:0] dir_y;
		logic signed [31:0] dir_z;
	} ray_t;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic signed [31:0] distance;
		logic        [16:0] coord_u;
		logic        [16:0] coord_v;
	} result_t;

	// Configuration snapshot carried with every item.
	typedef struct packed {
		logic signed [31:0] disk_height;
		logic        [30:0] disk_radius;
		logic signed [19:0] sweep_angle;
		logic signed [31:0] near_limit;
		logic signed [31:0] far_limit;
	} cfg_t;

	// Item classified by the front part.
	typedef struct packed {
		logic  skip;
		ray_t  ray;
		cfg_t  cfg;
	} job_t;

	function automatic logic [31:0] atan_q30(input int i);
		logic [31:0] r;
		case (i)
			0: r = 32'd843314856;  1: r = 32'd497837829;  2: r = 32'd263043836;
			3: r = 32'd133525158;  4: r = 32'd67021686;   5: r = 32'd33543515;
			6: r = 32'd16775850;   7: r = 32'd8388437;    8: r = 32'd4194282;
			9: r = 32'd2097149;    10: r = 32'd1048575;   11: r = 32'd524287;
			12: r = 32'd262143;    13: r = 32'd131071;    14: r = 32'd65535;
			15: r = 32'd32767;     16: r = 32'd16383;     17: r = 32'd8191;
			18: r = 32'd4095;      19: r = 32'd2047;      20: r = 32'd1023;
			21: r = 32'd511;       22: r = 32'd255;       23: r = 32'd127;
			24: r = 32'd63;        25: r = 32'd31;        26: r = 32'd15;
			27: r = 32'd7;         28: r = 32'd3;         29: r = 32'd1;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage

FILE: hdl/rpdi_stream_if.sv
interface rpdi_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/rpdi_front.sv
module rpdi_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  rpdi_pkg::ray_t in_data,
	input  rpdi_pkg::cfg_t cfg,
	output logic           job_valid,
	input  logic           job_ready,
	output rpdi_pkg::job_t job_data
);
	import rpdi_pkg::*;

	// Two-entry queue that parts the front from the back.
	job_t        mem_q [2];
	logic        wr_q, rd_q;
	logic [1:0]  cnt_q;
	logic        push, pop;
	job_t        job_new;

	always_comb begin
		job_new.ray = in_data;
		job_new.cfg = cfg;
		job_new.skip = (in_data.dir_z == '0) || (cfg.sweep_angle == '0) ||
			(cfg.disk_radius == '0);
	end

	assign in_ready  = (cnt_q != 2'd2);
	assign push      = in_valid && in_ready;
	assign job_valid = (cnt_q != 2'd0);
	assign pop       = job_valid && job_ready;
	assign job_data  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= job_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

FILE: hdl/rpdi_back.sv
module rpdi_back #(
	parameter int FRAC_BITS = rpdi_pkg::FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	output logic              job_ready,
	input  rpdi_pkg::job_t    job_data,
	output logic              out_valid,
	input  logic              out_ready,
	output rpdi_pkg::result_t out_data
);
	import rpdi_pkg::*;

	// Stage layout: 1 prep, 2..65 divider, 66 limit test and products,
	// 67 points, 68 magnitudes and box test, 69 squares, 70 radius test and
	// angle prescale, 71..100 CORDIC, 101 quadrant fold and sweep test,
	// 102..182 root, u and v division, 183 output register.
	// Every stage carries a valid bit; the pipe stalls as a whole.
	localparam int DIV_N = 64;
	localparam int CS = CORDIC_STEPS;

	logic adv;

	// ---------------- stage 1
	logic        v1;
	logic        neg1;
	logic [63:0] num1;
	logic [31:0] den1;
	job_t        j1;

	logic signed [32:0] num_s;
	assign num_s = $signed({job_data.cfg.disk_height[31], job_data.cfg.disk_height})
		- $signed({job_data.ray.origin_z[31], job_data.ray.origin_z});

	always_ff @(posedge clk) begin
		if (adv) begin
			j1   <= job_data;
			neg1 <= num_s[32] ^ job_data.ray.dir_z[31];
			num1 <= 64'(num_s[32] ? 33'(-num_s) : 33'(num_s)) << FRAC_BITS;
			den1 <= job_data.ray.dir_z[31] ? 32'(-job_data.ray.dir_z) : job_data.ray.dir_z;
		end
	end

	// ---------------- restoring divider, one quotient bit a stage
	logic [63:0] dq   [DIV_N+1];
	logic [32:0] drem [DIV_N+1];
	logic [31:0] dden [DIV_N+1];
	logic        dneg [DIV_N+1];
	job_t        dj   [DIV_N+1];
	logic        dv   [DIV_N+1];

	assign dq[0] = num1; assign drem[0] = '0; assign dden[0] = den1;
	assign dneg[0] = neg1; assign dj[0] = j1;
	assign dv[0] = v1;

	for (genvar g = 0; g < DIV_N; g++) begin : g_div
		logic [33:0] trial;
		logic [33:0] sh;
		assign sh = {drem[g], dq[g][63]};
		assign trial = sh - {2'b0, dden[g]};
		always_ff @(posedge clk) begin
			if (adv) begin
				if (!trial[33]) begin
					drem[g+1] <= trial[32:0];
					dq[g+1]   <= {dq[g][62:0], 1'b1};
				end else begin
					drem[g+1] <= sh[32:0];
					dq[g+1]   <= {dq[g][62:0], 1'b0};
				end
				dden[g+1] <= dden[g];
				dneg[g+1] <= dneg[g];
				dj[g+1]   <= dj[g];
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv[g+1] <= 1'b0;
			else if (adv) dv[g+1] <= dv[g];
		end
	end

	// ---------------- t and limit test, products
	logic signed [64:0] t_d;
	assign t_d = dneg[DIV_N] ? -$signed({1'b0, dq[DIV_N]}) : $signed({1'b0, dq[DIV_N]});

	logic               v2, sk2;
	logic signed [63:0] px2, py2, pz2;
	logic signed [31:0] t2;
	job_t               j2;

	always_ff @(posedge clk) begin
		if (adv) begin
			j2  <= dj[DIV_N];
			t2  <= t_d[31:0];
			sk2 <= dj[DIV_N].skip || (t_d < 65'(dj[DIV_N].cfg.near_limit))
				|| (t_d > 65'(dj[DIV_N].cfg.far_limit));
			px2 <= 64'($signed(t_d[31:0]) * dj[DIV_N].ray.dir_x);
			py2 <= 64'($signed(t_d[31:0]) * dj[DIV_N].ray.dir_y);
			pz2 <= 64'($signed(t_d[31:0]) * dj[DIV_N].ray.dir_z);
		end
	end

	// ---------------- points
	logic               v3, sk3;
	logic signed [48:0] px3, py3, pz3;
	logic signed [31:0] t3;
	job_t               j3;

	always_ff @(posedge clk) begin
		if (adv) begin
			j3  <= j2;
			t3  <= t2;
			sk3 <= sk2;
			px3 <= 49'(px2 >>> FRAC_BITS) + 49'(j2.ray.origin_x);
			py3 <= 49'(py2 >>> FRAC_BITS) + 49'(j2.ray.origin_y);
			pz3 <= 49'(pz2 >>> FRAC_BITS) + 49'(j2.ray.origin_z);
		end
	end

	// ---------------- magnitudes and box test
	logic        v4, sk4;
	logic [47:0] ax4, ay4;
	logic signed [48:0] px4, py4, pz4;
	logic signed [31:0] t4;
	job_t        j4;

	always_ff @(posedge clk) begin
		if (adv) begin
			j4  <= j3; t4 <= t3; px4 <= px3; py4 <= py3; pz4 <= pz3;
			ax4 <= px3[48] ? 48'(-px3) : 48'(px3);
			ay4 <= py3[48] ? 48'(-py3) : 48'(py3);
			sk4 <= sk3 || (48'(px3[48] ? -px3 : px3) > 48'(j3.cfg.disk_radius))
				|| (48'(py3[48] ? -py3 : py3) > 48'(j3.cfg.disk_radius));
		end
	end

	// ---------------- squares
	logic        v5, sk5;
	logic [61:0] xx5, yy5, rr5;
	logic [30:0] ax5, ay5;
	logic        sx5, sy5;
	logic [31:0] px5, py5, pz5, t5;
	job_t        j5;

	always_ff @(posedge clk) begin
		if (adv) begin
			j5  <= j4; sk5 <= sk4;
			ax5 <= ax4[30:0]; ay5 <= ay4[30:0];
			sx5 <= px4[48]; sy5 <= py4[48];
			xx5 <= ax4[30:0] * ax4[30:0];
			yy5 <= ay4[30:0] * ay4[30:0];
			rr5 <= j4.cfg.disk_radius * j4.cfg.disk_radius;
			px5 <= px4[31:0]; py5 <= py4[31:0]; t5 <= t4;
			pz5 <= (pz4 > 49'sd2147483647) ? 32'h7fffffff :
				(pz4 < -49'sd2147483648) ? 32'h80000000 : pz4[31:0];
		end
	end

	// ---------------- radius test, angle prescale
	logic        v6, sk6;
	logic [62:0] r26;
	logic [31:0] cx6, cy6;
	logic        az6, ax06;
	logic        sx6, sy6;
	logic [31:0] px6, py6, pz6, t6;
	job_t        j6;
	logic [62:0] r2c;
	logic [4:0]  lz;

	assign r2c = {1'b0, xx5} + {1'b0, yy5};
	// Shift that brings the larger magnitude into [2^30, 2^31).
	always_comb begin
		lz = 5'd0;
		for (int k = 30; k >= 1; k--) begin
			if (((ax5 | ay5) >> k) == 31'd0) lz = 5'(31 - k);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			j6 <= j5; px6 <= px5; py6 <= py5; pz6 <= pz5; t6 <= t5;
			sx6 <= sx5; sy6 <= sy5;
			r26 <= r2c;
			sk6 <= sk5 || (r2c > {1'b0, rr5});
			az6 <= (ay5 == '0);
			ax06 <= (ax5 == '0);
			cx6 <= {1'b0, ax5} << lz;
			cy6 <= {1'b0, ay5} << lz;
		end
	end

	// ---------------- CORDIC, one step a stage
	logic signed [34:0] cx [CS+1];
	logic signed [34:0] cy [CS+1];
	logic signed [34:0] cz [CS+1];
	logic               ca [CS+1];
	logic               cb [CS+1];
	logic               cv [CS+1];
	logic               csk [CS+1];
	logic [62:0]        cr2 [CS+1];
	logic [31:0]        cpx [CS+1], cpy [CS+1], cpz [CS+1], ct [CS+1];
	logic               csx [CS+1], csy [CS+1];
	job_t               cj [CS+1];

	assign cx[0] = $signed({3'b0, cx6}); assign cy[0] = $signed({3'b0, cy6});
	assign cz[0] = '0; assign ca[0] = az6; assign cb[0] = ax06; assign cv[0] = v6;
	assign csk[0] = sk6; assign cr2[0] = r26; assign cpx[0] = px6; assign cpy[0] = py6;
	assign cpz[0] = pz6; assign ct[0] = t6; assign csx[0] = sx6; assign csy[0] = sy6;
	assign cj[0] = j6;

	for (genvar g = 0; g < CS; g++) begin : g_cordic
		always_ff @(posedge clk) begin
			if (adv) begin
				if (!cy[g][34]) begin
					cx[g+1] <= cx[g] + (cy[g] >>> g);
					cy[g+1] <= cy[g] - (cx[g] >>> g);
					cz[g+1] <= cz[g] + $signed({3'b0, atan_q30(g)});
				end else begin
					cx[g+1] <= cx[g] - (cy[g] >>> g);
					cy[g+1] <= cy[g] + (cx[g] >>> g);
					cz[g+1] <= cz[g] - $signed({3'b0, atan_q30(g)});
				end
				ca[g+1] <= ca[g]; cb[g+1] <= cb[g]; csk[g+1] <= csk[g];
				cr2[g+1] <= cr2[g]; cpx[g+1] <= cpx[g]; cpy[g+1] <= cpy[g];
				cpz[g+1] <= cpz[g]; ct[g+1] <= ct[g]; csx[g+1] <= csx[g];
				csy[g+1] <= csy[g]; cj[g+1] <= cj[g];
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) cv[g+1] <= 1'b0;
			else if (adv) cv[g+1] <= cv[g];
		end
	end

	// ---------------- fold into quadrant, sweep test
	logic [34:0] phi, theta, theta_w, aa, swq;
	logic [19:0] sw_mag;
	always_comb begin
		if (ca[CS]) phi = '0;
		else if (cb[CS]) phi = HALF_PI_Q30;
		else if (cz[CS][34]) phi = '0;
		else if (cz[CS] > $signed(HALF_PI_Q30)) phi = HALF_PI_Q30;
		else phi = cz[CS];
		if (!csx[CS] && !csy[CS]) theta_w = phi;
		else if (csx[CS] && !csy[CS]) theta_w = PI_Q30 - phi;
		else if (csx[CS]) theta_w = PI_Q30 + phi;
		else theta_w = TWO_PI_Q30 - phi;
		theta = (theta_w >= TWO_PI_Q30) ? theta_w - TWO_PI_Q30 : theta_w;
		// Unsigned magnitude, so the most negative sweep gives 2^19.
		sw_mag = cj[CS].cfg.sweep_angle[19] ? 20'(-cj[CS].cfg.sweep_angle)
			: cj[CS].cfg.sweep_angle;
		swq = {15'd0, sw_mag} << (30 - FRAC_BITS);
		aa = cj[CS].cfg.sweep_angle[19] ? TWO_PI_Q30 - theta : theta;
	end

	logic        v7, sk7;
	logic [34:0] a7, s7;
	logic [62:0] r27;
	logic [30:0] rad7;
	logic [31:0] px7, py7, pz7, t7;

	always_ff @(posedge clk) begin
		if (adv) begin
			sk7 <= csk[CS] || (aa > swq);
			a7 <= aa; s7 <= swq; r27 <= cr2[CS]; rad7 <= cj[CS].cfg.disk_radius;
			px7 <= cpx[CS]; py7 <= cpy[CS]; pz7 <= cpz[CS]; t7 <= ct[CS];
		end
	end

	// ---------------- u division, root and v division in lockstep
	// Root: the first 32 stages; v: 49 quotient bits in the 49 stages after
	// it; u: 52 quotient bits in the first 52 stages, then held.
	localparam int RN = 32;
	localparam int VN = 49;
	localparam int UN = 17;
	localparam int TN = RN + VN;

	logic [63:0] sr_v [RN+1];
	logic [63:0] sr_r [TN+1];
	logic [63:0] sr_b [RN+1];
	logic [51:0] uq   [TN+1];
	logic [35:0] ur   [TN+1];
	logic [34:0] us   [TN+1];
	logic [48:0] vq   [TN+1];
	logic [31:0] vr   [TN+1];
	logic [30:0] vd   [TN+1];
	logic        tv   [TN+1];
	logic        tsk  [TN+1];
	logic [31:0] tpx [TN+1], tpy [TN+1], tpz [TN+1], tt [TN+1];

	assign sr_v[0] = {1'b0, r27}; assign sr_r[0] = '0; assign sr_b[0] = 64'h4000000000000000;
	assign uq[0] = {1'b0, a7, 16'b0}; assign ur[0] = '0; assign us[0] = s7;
	assign vd[0] = rad7; assign tv[0] = v7; assign tsk[0] = sk7;
	assign tpx[0] = px7; assign tpy[0] = py7; assign tpz[0] = pz7; assign tt[0] = t7;
	assign vq[0] = '0; assign vr[0] = '0;

	for (genvar g = 0; g < TN; g++) begin : g_tail
		logic [36:0] ush, utr;
		assign ush = {ur[g], uq[g][51]};
		assign utr = ush - {2'b0, us[g]};
		if (g < RN) begin : g_root
			logic [63:0] rb;
			assign rb = sr_r[g] + sr_b[g];
			always_ff @(posedge clk) begin
				if (adv) begin
					if (sr_v[g] >= rb) begin
						sr_v[g+1] <= sr_v[g] - rb;
						sr_r[g+1] <= (sr_r[g] >> 1) + sr_b[g];
					end else begin
						sr_v[g+1] <= sr_v[g];
						sr_r[g+1] <= sr_r[g] >> 1;
					end
					sr_b[g+1] <= sr_b[g] >> 2;
					vq[g+1] <= '0; vr[g+1] <= '0;
				end
			end
		end else begin : g_vdiv
			// dividend bits: root (32 bits) followed by 16 zeros, MSB first
			localparam int BI = (g - RN < 33) ? 32 - (g - RN) : 0;
			logic [32:0] vsh, vtr;
			logic        nb;
			assign nb = (g - RN < 33) ? sr_r[g][BI] : 1'b0;
			assign vsh = {vr[g], nb};
			assign vtr = vsh - {2'b0, vd[g]};
			always_ff @(posedge clk) begin
				if (adv) begin
					if (!vtr[32]) begin
						vr[g+1] <= vtr[31:0]; vq[g+1] <= {vq[g][47:0], 1'b1};
					end else begin
						vr[g+1] <= vsh[31:0]; vq[g+1] <= {vq[g][47:0], 1'b0};
					end
				end
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				if (g < 52 && !utr[36]) begin
					ur[g+1] <= utr[35:0]; uq[g+1] <= {uq[g][50:0], 1'b1};
				end else if (g < 52) begin
					ur[g+1] <= ush[35:0]; uq[g+1] <= {uq[g][50:0], 1'b0};
				end else begin
					ur[g+1] <= ur[g]; uq[g+1] <= uq[g];
				end
				us[g+1] <= us[g]; vd[g+1] <= vd[g]; tsk[g+1] <= tsk[g];
				tpx[g+1] <= tpx[g]; tpy[g+1] <= tpy[g]; tpz[g+1] <= tpz[g];
				tt[g+1] <= tt[g];
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) tv[g+1] <= 1'b0;
			else if (adv) tv[g+1] <= tv[g];
		end
	end

	// root must stay visible through the v division
	for (genvar g = RN; g < TN; g++) begin : g_rpass
		always_ff @(posedge clk) begin
			if (adv) sr_r[g+1] <= sr_r[g];
		end
	end

	// stage valids between the named stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
			v5 <= 1'b0; v6 <= 1'b0; v7 <= 1'b0;
		end else if (adv) begin
			v1 <= job_valid; v2 <= dv[DIV_N]; v3 <= v2; v4 <= v3;
			v5 <= v4; v6 <= v5; v7 <= cv[CS];
		end
	end

	// ---------------- output register
	logic [48:0] vfrac;
	result_t     res;
	assign vfrac = (vq[TN] > 49'd65536) ? 49'd65536 : vq[TN];

	always_comb begin
		res = '0;
		if (!tsk[TN]) begin
			res.hit = 1'b1;
			res.point_x = tpx[TN]; res.point_y = tpy[TN]; res.point_z = tpz[TN];
			res.distance = tt[TN];
			res.coord_u = uq[TN][16:0];
			res.coord_v = 17'd65536 - vfrac[16:0];
		end
	end

	assign adv = !out_valid || out_ready;
	assign job_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (adv) out_valid <= tv[TN];
	end
	always_ff @(posedge clk) begin
		if (adv) out_data <= res;
	end

	`include "ray_partial_disk_intersect_assert.svh"
	`RPD_ASSERT_NXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`RPD_ASSERT_IMP(a_miss_zero, clk, arst_n, out_valid && !out_data.hit, out_data.coord_u == '0)
	`RPD_ASSERT_IMP(a_u_range, clk, arst_n, out_valid, out_data.coord_u <= 17'd65536)
endmodule

FILE: hdl/ray_partial_disk_intersect.sv
// Ray against partial disk intersection.
// Rays enter on in_ch (origin and direction, signed Q16.16) and one result
// item leaves on out_ch for every ray, in order: hit flag, hit point,
// ray distance and the u, v surface coordinates; a miss gives all zeros.
// Configuration (height, radius, sweep, near and far limits) is written
// through cfg_we / cfg_idx / cfg_data; the user must do so only while the
// block is idle, which the block itself does not enforce. A front part
// snapshots the configuration with each ray, flags rays that can never hit
// and places them in a two-entry queue. A back part is one long pipeline:
// a one-bit-a-stage divider for t, the point products, the radius test,
// a 30-stage CORDIC for the polar angle and stages for the root and the
// u and v quotients.
// Throughput is one ray per cycle; the whole back pipeline advances
// together whenever the output register is empty or being taken.
// When the receiver stalls, the output holds, the pipeline freezes and
// the queue fills, after which in_ch.ready drops.
// Reset clears all valid bits and loads the register defaults.
module ray_partial_disk_intersect #(
	parameter int FRAC_BITS = rpdi_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	rpdi_stream_if.sink                        in_ch,
	rpdi_stream_if.source                      out_ch,
	input  logic                               cfg_we,
	input  logic [rpdi_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [rpdi_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import rpdi_pkg::*;

	cfg_t cfg_q;
	logic job_valid, job_ready;
	job_t job_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.disk_height <= '0;
			cfg_q.disk_radius <= 31'(1 << FRAC_BITS);
			cfg_q.sweep_angle <= 20'd411775;
			cfg_q.near_limit  <= '0;
			cfg_q.far_limit   <= 32'h7fffffff;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_HEIGHT: cfg_q.disk_height <= cfg_data;
				REG_RADIUS: cfg_q.disk_radius <= cfg_data[30:0];
				REG_SWEEP:  cfg_q.sweep_angle <= cfg_data[19:0];
				REG_NEAR:   cfg_q.near_limit  <= cfg_data;
				REG_FAR:    cfg_q.far_limit   <= cfg_data;
				default: ;
			endcase
		end
	end

	rpdi_front u_front (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
		.cfg(cfg_q),
		.job_valid, .job_ready, .job_data
	);

	rpdi_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk, .arst_n,
		.job_valid, .job_ready, .job_data,
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
	);
endmodule

FILE: tb/ray_disk_checker.sv
`timescale 1ns / 1ps

module ray_disk_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               ray_valid,
	input  logic                               ray_ready,
	input  rpdi_pkg::ray_t                     ray,
	input  logic                               res_valid,
	input  logic                               res_ready,
	input  rpdi_pkg::result_t                  res,
	input  logic                               cfg_we,
	input  logic [rpdi_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [rpdi_pkg::CFG_DATA_W-1:0]    cfg_data,
	output int                                 errors,
	output int                                 pending,
	output int                                 hits_seen
);
	import rpdi_pkg::*;

	localparam int FB = FRAC_BITS_DEF;

	logic signed [31:0] height;
	logic        [30:0] radius;
	logic signed [19:0] sweep;
	logic signed [31:0] near_t;
	logic signed [31:0] far_t;

	result_t expected_results[$];

	function automatic longint unsigned magnitude(longint v);
		return (v < 0) ? longint'(0) - v : v;
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Vectoring rotation on the magnitudes; angle in Q30 within a quarter turn.
	function automatic longint quarter_angle(longint unsigned ax, longint unsigned ay);
		longint x;
		longint y;
		longint z;
		longint xs;
		longint ys;
		z = 0;
		if (ay == 0)
			return 0;
		if (ax == 0)
			return longint'(HALF_PI_Q30);
		while (ax < (64'd1 << 30) && ay < (64'd1 << 30)) begin
			ax = ax << 1;
			ay = ay << 1;
		end
		x = ax;
		y = ay;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z = z + longint'(atan_q30(i));
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - longint'(atan_q30(i));
			end
		end
		if (z < 0)
			z = 0;
		if (z > longint'(HALF_PI_Q30))
			z = longint'(HALF_PI_Q30);
		return z;
	endfunction

	function automatic result_t intersect_disk(ray_t r);
		result_t o;
		longint num;
		longint t;
		longint px;
		longint py;
		longint pz;
		longint phi;
		longint theta;
		longint a;
		longint swq;
		longint unsigned q;
		longint unsigned ax;
		longint unsigned ay;
		longint unsigned r2;
		longint unsigned frac;
		o = '0;
		if (r.dir_z == 0 || sweep == 0 || radius == 0)
			return o;
		num = longint'(height) - longint'(r.origin_z);
		q = (magnitude(num) << FB) / magnitude(longint'(r.dir_z));
		t = ((num < 0) != (r.dir_z < 0)) ? -longint'(q) : longint'(q);
		if (t < longint'(near_t) || t > longint'(far_t))
			return o;
		px = longint'(r.origin_x) + ((t * longint'(r.dir_x)) >>> FB);
		py = longint'(r.origin_y) + ((t * longint'(r.dir_y)) >>> FB);
		pz = longint'(r.origin_z) + ((t * longint'(r.dir_z)) >>> FB);
		ax = magnitude(px);
		ay = magnitude(py);
		if (ax > longint'(radius) || ay > longint'(radius))
			return o;
		r2 = ax * ax + ay * ay;
		if (r2 > longint'(radius) * longint'(radius))
			return o;
		phi = quarter_angle(ax, ay);
		if (px >= 0 && py >= 0)
			theta = phi;
		else if (px < 0 && py >= 0)
			theta = longint'(PI_Q30) - phi;
		else if (px < 0)
			theta = longint'(PI_Q30) + phi;
		else
			theta = longint'(TWO_PI_Q30) - phi;
		if (theta >= longint'(TWO_PI_Q30))
			theta = theta - longint'(TWO_PI_Q30);
		swq = magnitude(longint'(sweep)) << (30 - FB);
		a = (sweep < 0) ? longint'(TWO_PI_Q30) - theta : theta;
		if (a > swq)
			return o;
		frac = (root_floor(r2) << UV_BITS) / longint'(radius);
		if (frac > (64'd1 << UV_BITS))
			frac = 64'd1 << UV_BITS;
		o.hit = 1'b1;
		o.point_x = px[31:0];
		o.point_y = py[31:0];
		o.point_z = 32'(clamp32(pz));
		o.distance = 32'(clamp32(t));
		o.coord_u = 17'(longint'(a << UV_BITS) / swq);
		o.coord_v = 17'((64'd1 << UV_BITS) - frac);
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t e;
		string bad;
		if (!arst_n) begin
			height <= '0;
			radius <= 31'd65536;
			sweep <= 20'sd411775;
			near_t <= '0;
			far_t <= 32'sh7FFFFFFF;
			errors <= 0;
			hits_seen <= 0;
			expected_results.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_HEIGHT: height <= cfg_data;
					REG_RADIUS: radius <= cfg_data[30:0];
					REG_SWEEP:  sweep <= cfg_data[19:0];
					REG_NEAR:   near_t <= cfg_data;
					REG_FAR:    far_t <= cfg_data;
					default: ;
				endcase
			end
			if (ray_valid && ray_ready)
				expected_results.push_back(intersect_disk(ray));
			if (res_valid && res_ready) begin
				if (expected_results.size() == 0) begin
					errors <= errors + 1;
					if (errors < 10)
						$display("ERROR: result item with nothing expected: %p", res);
				end else begin
					e = expected_results.pop_front();
					bad = "";
					if (res.hit !== e.hit) bad = {bad, " hit"};
					if (res.point_x !== e.point_x) bad = {bad, " point_x"};
					if (res.point_y !== e.point_y) bad = {bad, " point_y"};
					if (res.point_z !== e.point_z) bad = {bad, " point_z"};
					if (res.distance !== e.distance) bad = {bad, " distance"};
					if (res.coord_u !== e.coord_u) bad = {bad, " coord_u"};
					if (res.coord_v !== e.coord_v) bad = {bad, " coord_v"};
					if (bad != "") begin
						errors <= errors + 1;
						if (errors < 10) begin
							$display("ERROR: mismatch in%s", bad);
							$display("  expected %p", e);
							$display("  actual   %p", res);
						end
					end
					if (e.hit)
						hits_seen <= hits_seen + 1;
				end
			end
		end
	end

	assign pending = expected_results.size();

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import rpdi_pkg::*;

	// Generous bound: ~1200 items, heavy stalls, long hold-offs and drains.
	localparam int CYCLE_LIMIT = 600000;
	localparam int PIPE_WAIT = 300;
	localparam int NUM_SETTINGS = 9;
	localparam int RANDOM_PER_SETTING = 130;
	// An index past the last register.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	rpdi_stream_if #(.payload_t(ray_t)) ray_ch ();
	rpdi_stream_if #(.payload_t(result_t)) res_ch ();

	int errors;
	int pending;
	int hits_seen;
	int cycles = 0;
	int rays_sent;

	// Idle percentages for the sending and receiving sides.
	int send_idle_pct;
	int recv_stall_pct;

	// The receiver runs its own hold-off counter; the stimulus only asks for one.
	int hold_requests;
	int hold_served;
	int hold_left;

	// Local copy of the disk setup, used only to aim rays at the disk.
	logic signed [31:0] aim_height;
	logic        [30:0] aim_radius;

	ray_partial_disk_intersect dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (ray_ch),
		.out_ch   (res_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	ray_disk_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.ray_valid (ray_ch.valid),
		.ray_ready (ray_ch.ready),
		.ray       (ray_ch.data),
		.res_valid (res_ch.valid),
		.res_ready (res_ch.ready),
		.res       (res_ch.data),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending),
		.hits_seen (hits_seen)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog: any hang or lost result ends here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("ERROR: timeout after %0d cycles, %0d results outstanding",
				cycles, pending);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Result side. A requested hold-off drops ready for a long stretch so that
	// the pipeline freezes, the input queue fills and ray_ch.ready goes low.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			hold_served <= 0;
			hold_left <= 0;
		end else if (hold_served != hold_requests) begin
			hold_served <= hold_requests;
			hold_left <= 400;
			res_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Offers one ray and returns once it is taken. valid is left high so that
	// back-to-back rays need no second assignment in the same time step.
	task automatic offer_ray(input ray_t r);
		if ($urandom_range(99) < send_idle_pct) begin
			ray_ch.valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		ray_ch.valid <= 1'b1;
		ray_ch.data <= r;
		do
			@(posedge clk);
		while (!ray_ch.ready);
		rays_sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		if (idx == REG_HEIGHT)
			aim_height = val;
		if (idx == REG_RADIUS)
			aim_radius = val[30:0];
	endtask

	// Drains the block: all results back, then the pipeline latency on top,
	// since configuration may only change while nothing is in flight.
	task automatic drain;
		ray_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (PIPE_WAIT) @(posedge clk);
	endtask

	function automatic ray_t make_ray(input longint ox, input longint oy, input longint oz,
		input longint dx, input longint dy, input longint dz);
		ray_t r;
		r.origin_x = ox[31:0];
		r.origin_y = oy[31:0];
		r.origin_z = oz[31:0];
		r.dir_x = dx[31:0];
		r.dir_y = dy[31:0];
		r.dir_z = dz[31:0];
		return r;
	endfunction

	function automatic ray_t random_ray;
		return make_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
	endfunction

	// Aims a ray at a random point near the disk: a whole-unit distance keeps
	// the quotient exact, and the target spreads a little past the rim so that
	// the radius and angle tests see both outcomes.
	function automatic ray_t aimed_ray;
		longint rad;
		longint tx;
		longint ty;
		longint tt;
		longint dx;
		longint dy;
		longint dz;
		rad = aim_radius;
		if (rad > 64'd1 << 29)
			rad = 64'd1 << 29;
		rad = rad + rad / 8 + 1;
		tx = longint'($urandom_range(32'(2 * rad))) - rad;
		ty = longint'($urandom_range(32'(2 * rad))) - rad;
		if ($urandom_range(9) == 0)
			tx = 0;
		if ($urandom_range(9) == 0)
			ty = 0;
		tt = longint'($urandom_range(7)) - 1;
		dz = (longint'($urandom_range(1, 4)) << 16) + $urandom_range(65535);
		if ($urandom_range(1))
			dz = -dz;
		dx = longint'($urandom_range(262143)) - 131072;
		dy = longint'($urandom_range(262143)) - 131072;
		return make_ray(tx - tt * dx, ty - tt * dy, longint'(aim_height) - tt * dz,
			dx, dy, dz);
	endfunction

	// Mostly aimed rays, the rest noise and parallel rays.
	function automatic ray_t mixed_ray;
		ray_t r;
		int pick;
		pick = $urandom_range(99);
		if (pick < 75) begin
			r = aimed_ray();
		end else if (pick < 92) begin
			r = random_ray();
		end else begin
			r = aimed_ray();
			r.dir_z = '0;
		end
		return r;
	endfunction

	task automatic directed_rays;
		// Field extremes, all ones and all zeros.
		offer_ray(make_ray(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
		offer_ray(make_ray(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
			-64'sd2147483648, -64'sd2147483648, -64'sd2147483648));
		offer_ray('0);
		offer_ray(make_ray(-1, -1, -1, -1, -1, -1));
		// Parallel ray that would otherwise sit on the disk.
		offer_ray(make_ray(0, 0, 65536, 0, 0, 0));
		// Straight down onto the center: angle zero.
		offer_ray(make_ray(0, 0, 65536, 0, 0, -65536));
		// Points on each axis: quarter, half and three-quarter turns and zero.
		offer_ray(make_ray(0, 32768, 65536, 0, 0, -65536));
		offer_ray(make_ray(-32768, 0, 65536, 0, 0, -65536));
		offer_ray(make_ray(0, -32768, 65536, 0, 0, -65536));
		offer_ray(make_ray(32768, 0, 65536, 0, 0, -65536));
		// Exactly on the rim, just past it, and far off.
		offer_ray(make_ray(65536, 0, 65536, 0, 0, -65536));
		offer_ray(make_ray(46341, 46341, 65536, 0, 0, -65536));
		offer_ray(make_ray(32'h40000000, 5, 65536, 0, 0, -65536));
		// Plane behind the origin: negative distance, under the near limit.
		offer_ray(make_ray(1000, 1000, 65536, 0, 0, 65536));
		// Oblique ray with a smallest direction step.
		offer_ray(make_ray(-20000, 30000, 131072, 7, -3, -1));
		// Fourth quadrant point and a point just below the x axis.
		offer_ray(make_ray(20000, -30000, -65536, 0, 0, 65536));
		offer_ray(make_ray(30000, -1, -65536, 0, 0, 65536));
	endtask

	// Register sets applied in turn: height, radius, sweep, near, far.
	// They cover a half turn, a quarter turn and a full turn clockwise,
	// a sweep past a full turn, zero sweep, zero radius, the widest radius,
	// tight distance windows and both extremes of the height.
	logic [31:0] setting_regs [NUM_SETTINGS][5] = '{
		'{32'd0, 32'd65536, 32'd411775, 32'd0, 32'h7FFFFFFF},
		'{32'd131072, 32'd196608, 32'd205887, 32'd0, 32'h7FFFFFFF},
		'{-32'sd327680, 32'd65536, -32'sd102944, 32'h80000000, 32'd655360},
		'{32'd0, 32'h7FFFFFFF, -32'sd411775, 32'h80000000, 32'h7FFFFFFF},
		'{32'd0, 32'd131072, 32'd0, 32'd0, 32'h7FFFFFFF},
		'{32'd65536, 32'd0, 32'd411775, 32'd0, 32'h7FFFFFFF},
		'{32'h7FFFFFFF, 32'd65536, 32'd480000, 32'h80000000, 32'h7FFFFFFF},
		'{32'h80000000, 32'd262144, 32'd1, 32'd0, 32'h7FFFFFFF},
		'{32'd0, 32'd65536, 32'd300000, 32'd131072, 32'd262144}
	};

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		ray_ch.valid = 1'b0;
		ray_ch.data = '0;
		rays_sent = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_requests = 0;
		aim_height = '0;
		aim_radius = 31'd65536;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values are checked first, with no writes at all.
		directed_rays();
		for (int s = 0; s < NUM_SETTINGS; s++) begin
			drain();
			if (s > 0) begin
				for (int k = 0; k < 5; k++)
					write_reg(k[CFG_IDX_W-1:0], setting_regs[s][k]);
				// An unused index must leave every register as it is.
				if (s == 1)
					write_reg(REG_UNUSED, 32'hFFFFFFFF);
				cfg_we <= 1'b0;
				@(posedge clk);
			end
			for (int i = 0; i < RANDOM_PER_SETTING; i++) begin
				// The idling pattern changes every quarter of a setting, so each
				// pattern meets every register setting.
				case ((i * 4) / RANDOM_PER_SETTING)
					0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
					1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
					2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
					default: begin send_idle_pct = 8; recv_stall_pct = 8; end
				endcase
				// Long receiver hold-off while rays keep coming at full rate.
				if (i == 10 && (s == 2 || s == 6))
					hold_requests++;
				// Sender pause until every outstanding result is back.
				if (i == 70 && s == 3) begin
					ray_ch.valid <= 1'b0;
					@(posedge clk);
					while (pending != 0)
						@(posedge clk);
				end
				offer_ray(mixed_ray());
			end
		end
		drain();

		$display("Covered %0d rays over %0d disk setups, %0d of them hits.",
			rays_sent, NUM_SETTINGS, hits_seen);
		$display("Idle patterns, receiver hold-offs and a full drain mid-stream included.");
		if (errors == 0 && pending == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

FILE: ray_partial_disk_intersect.f
+incdir+hdl
hdl/rpdi_pkg.sv
hdl/rpdi_stream_if.sv
hdl/rpdi_front.sv
hdl/rpdi_back.sv
hdl/ray_partial_disk_intersect.sv
tb/ray_disk_checker.sv
tb/tb_top.sv
